>>> design/iqmh_pkg.sv
// shared types, constants and command codes for the indexed quad min-heap
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package iqmh_pkg;

	localparam int MAX_NODES = 1024;
	localparam int KEY_W     = 32;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = NODE_W + 1;
	localparam int CIDX_W    = NODE_W + 2;

	localparam logic signed [KEY_W-1:0] KEY_ABSENT = {1'b0, {(KEY_W-1){1'b1}}};

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	typedef logic [4:0] cmd_t;

	localparam cmd_t CMD_NOP         = 5'd0;
	localparam cmd_t CMD_LOAD        = 5'd1;
	localparam cmd_t CMD_INIT_WR     = 5'd2;
	localparam cmd_t CMD_RD_POS      = 5'd3;
	localparam cmd_t CMD_RD_SLOT_POS = 5'd4;
	localparam cmd_t CMD_PUSH_NEW    = 5'd5;
	localparam cmd_t CMD_UP_RD       = 5'd6;
	localparam cmd_t CMD_UP_SHIFT    = 5'd7;
	localparam cmd_t CMD_PLACE       = 5'd8;
	localparam cmd_t CMD_POP_RD      = 5'd9;
	localparam cmd_t CMD_POP_ROOT    = 5'd10;
	localparam cmd_t CMD_POP_LAST    = 5'd11;
	localparam cmd_t CMD_DN_START    = 5'd12;
	localparam cmd_t CMD_DN_CMP      = 5'd13;
	localparam cmd_t CMD_DN_SHIFT    = 5'd14;
	localparam cmd_t CMD_Q_FOUND     = 5'd15;
	localparam cmd_t CMD_CLR_RD      = 5'd16;
	localparam cmd_t CMD_CLR_WR      = 5'd17;
	localparam cmd_t CMD_CLR_END     = 5'd18;
	localparam cmd_t CMD_FIN         = 5'd19;

	typedef struct packed {
		logic [1:0]              operation;
		logic [NODE_W-1:0]       node;
		logic signed [KEY_W-1:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [NODE_W-1:0]       result_node;
		logic signed [KEY_W-1:0] result_priority;
		logic                    found;
		logic [CNT_W-1:0]        entry_count;
	} res_t;

	typedef struct packed {
		logic [NODE_W-1:0]       node;
		logic signed [KEY_W-1:0] key;
	} slot_t;

	typedef struct packed {
		logic              valid;
		logic [NODE_W-1:0] slot;
	} pos_t;

	typedef struct packed {
		logic [1:0] op;
		logic       err;
		logic       pos_valid;
		logic       key_less;
		logic       held_full;
		logic       held_zero;
		logic       cur_zero;
		logic       parent_gt;
		logic       dn_leaf;
		logic       dn_more;
		logic       best_is_cur;
		logic       clr_done;
		logic       init_done;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> design/iqmh_ram.sv
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module iqmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/iqmh_datapath.sv
// heap and position memories, working registers and result registers
// depends on iqmh_pkg and iqmh_ram
`timescale 1ns / 1ps
`default_nettype none

module iqmh_datapath import iqmh_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cmd_t       cmd,
	input  wire req_t       request,
	input  wire logic       cfg_wr_en,
	input  wire logic [CNT_W-1:0] cfg_wr_data,
	output      dp_stat_t   stat,
	output      logic       done,
	output      res_t       result
);

	logic [CNT_W-1:0]        node_count_q;
	logic [CNT_W-1:0]        held_q;
	logic [CIDX_W-1:0]       c_q;
	logic                    done_q;
	logic [1:0]              op_q;
	logic [NODE_W-1:0]       node_q;
	logic [NODE_W-1:0]       mov_node_q;
	logic signed [KEY_W-1:0] mov_key_q;
	logic [NODE_W-1:0]       cur_q;
	logic [NODE_W-1:0]       best_node_q;
	logic signed [KEY_W-1:0] best_key_q;
	logic [NODE_W-1:0]       best_idx_q;
	logic [1:0]              res_status_q;
	logic [NODE_W-1:0]       res_node_q;
	logic signed [KEY_W-1:0] res_key_q;
	logic                    found_q;

	logic              h_we, h_re, p_we, p_re;
	logic [NODE_W-1:0] h_waddr, h_raddr, p_waddr, p_raddr;
	slot_t             h_wdata, h_rdata;
	pos_t              p_wdata, p_rdata;

	logic [NODE_W-1:0] cur_m1;
	logic [NODE_W-1:0] parent_idx;
	logic [CIDX_W-1:0] c_first;
	logic [CIDX_W-1:0] c_next;
	logic [CIDX_W-1:0] held_ext;
	logic [CNT_W-1:0]  held_m1;
	logic              in_range;
	logic [1:0]        load_status;

	iqmh_ram #(.WIDTH($bits(slot_t)), .DEPTH(MAX_NODES)) u_heap (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.re(h_re), .raddr(h_raddr), .rdata(h_rdata)
	);

	iqmh_ram #(.WIDTH($bits(pos_t)), .DEPTH(MAX_NODES)) u_pos (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.re(p_re), .raddr(p_raddr), .rdata(p_rdata)
	);

	assign cur_m1     = cur_q - NODE_W'(1);
	assign parent_idx = {2'b00, cur_m1[NODE_W-1:2]};
	assign c_first    = {cur_q, 2'b01};
	assign c_next     = c_q + CIDX_W'(1);
	assign held_ext   = {1'b0, held_q};
	assign held_m1    = held_q - CNT_W'(1);
	assign in_range   = {1'b0, request.node} < node_count_q;

	always_comb begin
		load_status = STAT_OK;
		if ((request.operation == OP_PUSH || request.operation == OP_QUERY) && !in_range) begin
			load_status = STAT_RANGE;
		end else if (request.operation == OP_POP && held_q == '0) begin
			load_status = STAT_EMPTY;
		end
	end

	always_comb begin
		stat.op          = op_q;
		stat.err         = res_status_q != STAT_OK;
		stat.pos_valid   = p_rdata.valid;
		stat.key_less    = $signed(mov_key_q) < $signed(h_rdata.key);
		stat.held_full   = held_q == CNT_W'(MAX_NODES);
		stat.held_zero   = held_q == '0;
		stat.cur_zero    = cur_q == '0;
		stat.parent_gt   = $signed(h_rdata.key) > $signed(mov_key_q);
		stat.dn_leaf     = c_first >= held_ext;
		stat.dn_more     = (c_q[1:0] != 2'b00) && (c_next < held_ext);
		stat.best_is_cur = best_idx_q == cur_q;
		stat.clr_done    = c_q >= held_ext;
		stat.init_done   = c_q[NODE_W-1:0] == NODE_W'(MAX_NODES - 1);
	end

	// memory port decode
	always_comb begin
		h_we    = 1'b0;
		h_waddr = cur_q;
		h_wdata = {mov_node_q, mov_key_q};
		h_re    = 1'b0;
		h_raddr = c_q[NODE_W-1:0];
		p_we    = 1'b0;
		p_waddr = mov_node_q;
		p_wdata = {1'b1, cur_q};
		p_re    = 1'b0;
		p_raddr = node_q;
		unique case (cmd)
			CMD_INIT_WR: begin
				p_we    = 1'b1;
				p_waddr = c_q[NODE_W-1:0];
				p_wdata = '0;
			end
			CMD_RD_POS: begin
				p_re = 1'b1;
			end
			CMD_RD_SLOT_POS: begin
				h_re    = 1'b1;
				h_raddr = p_rdata.slot;
			end
			CMD_UP_RD: begin
				h_re    = 1'b1;
				h_raddr = parent_idx;
			end
			CMD_UP_SHIFT: begin
				h_we    = 1'b1;
				h_wdata = h_rdata;
				p_we    = 1'b1;
				p_waddr = h_rdata.node;
			end
			CMD_PLACE: begin
				h_we = 1'b1;
				p_we = 1'b1;
			end
			CMD_POP_RD: begin
				h_re    = 1'b1;
				h_raddr = '0;
			end
			CMD_POP_ROOT: begin
				p_we    = 1'b1;
				p_waddr = h_rdata.node;
				p_wdata = '0;
				h_re    = 1'b1;
				h_raddr = held_m1[NODE_W-1:0];
			end
			CMD_DN_START: begin
				h_re    = 1'b1;
				h_raddr = c_first[NODE_W-1:0];
			end
			CMD_DN_CMP: begin
				h_re    = 1'b1;
				h_raddr = c_next[NODE_W-1:0];
			end
			CMD_DN_SHIFT: begin
				h_we    = 1'b1;
				h_wdata = {best_node_q, best_key_q};
				p_we    = 1'b1;
				p_waddr = best_node_q;
			end
			CMD_CLR_RD: begin
				h_re = 1'b1;
			end
			CMD_CLR_WR: begin
				p_we    = 1'b1;
				p_waddr = h_rdata.node;
				p_wdata = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(MAX_NODES);
			held_q       <= '0;
			c_q          <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr_en) begin
				node_count_q <= cfg_wr_data;
			end
			unique case (cmd)
				CMD_LOAD:     c_q    <= '0;
				CMD_INIT_WR:  c_q    <= c_next;
				CMD_PUSH_NEW: held_q <= held_q + CNT_W'(1);
				CMD_POP_ROOT: held_q <= held_m1;
				CMD_DN_START: c_q    <= c_first;
				CMD_DN_CMP:   c_q    <= c_next;
				CMD_CLR_WR:   c_q    <= c_next;
				CMD_CLR_END:  held_q <= '0;
				CMD_FIN:      done_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_LOAD: begin
				op_q         <= request.operation;
				node_q       <= request.node;
				mov_node_q   <= request.node;
				mov_key_q    <= request.priority_req;
				res_status_q <= load_status;
				res_node_q   <= '0;
				res_key_q    <= (request.operation == OP_QUERY) ? KEY_ABSENT : '0;
				found_q      <= 1'b0;
			end
			CMD_RD_SLOT_POS: cur_q <= p_rdata.slot;
			CMD_PUSH_NEW:    cur_q <= held_q[NODE_W-1:0];
			CMD_UP_SHIFT:    cur_q <= parent_idx;
			CMD_POP_ROOT: begin
				res_node_q <= h_rdata.node;
				res_key_q  <= h_rdata.key;
			end
			CMD_POP_LAST: begin
				mov_node_q <= h_rdata.node;
				mov_key_q  <= h_rdata.key;
				cur_q      <= '0;
			end
			CMD_DN_START: begin
				best_node_q <= mov_node_q;
				best_key_q  <= mov_key_q;
				best_idx_q  <= cur_q;
			end
			CMD_DN_CMP: begin
				if ($signed(h_rdata.key) < $signed(best_key_q)) begin
					best_node_q <= h_rdata.node;
					best_key_q  <= h_rdata.key;
					best_idx_q  <= c_q[NODE_W-1:0];
				end
			end
			CMD_DN_SHIFT: cur_q <= best_idx_q;
			CMD_Q_FOUND: begin
				found_q   <= 1'b1;
				res_key_q <= h_rdata.key;
			end
			default: begin
			end
		endcase
	end

	assign done                   = done_q;
	assign result.status          = res_status_q;
	assign result.result_node     = res_node_q;
	assign result.result_priority = res_key_q;
	assign result.found           = found_q;
	assign result.entry_count     = held_q;

endmodule

`default_nettype wire

>>> design/iqmh_ctrl.sv
// operation sequencer for the heap: issues one datapath command per cycle
// depends on iqmh_pkg
`timescale 1ns / 1ps
`default_nettype none

module iqmh_ctrl import iqmh_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire dp_stat_t stat,
	output      logic     busy,
	output      cmd_t     cmd
);

	localparam logic [4:0] S_INIT     = 5'd0;
	localparam logic [4:0] S_IDLE     = 5'd1;
	localparam logic [4:0] S_DISP     = 5'd2;
	localparam logic [4:0] S_PUSH_POS = 5'd3;
	localparam logic [4:0] S_PUSH_KEY = 5'd4;
	localparam logic [4:0] S_UP       = 5'd5;
	localparam logic [4:0] S_UP_CMP   = 5'd6;
	localparam logic [4:0] S_POP_ROOT = 5'd7;
	localparam logic [4:0] S_POP_CHK  = 5'd8;
	localparam logic [4:0] S_DN       = 5'd9;
	localparam logic [4:0] S_DN_CMP   = 5'd10;
	localparam logic [4:0] S_DN_MOVE  = 5'd11;
	localparam logic [4:0] S_Q_POS    = 5'd12;
	localparam logic [4:0] S_Q_KEY    = 5'd13;
	localparam logic [4:0] S_CLR_RD   = 5'd14;
	localparam logic [4:0] S_CLR_WR   = 5'd15;
	localparam logic [4:0] S_FIN      = 5'd16;

	logic [4:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NOP;
		unique case (state_q)
			S_INIT: begin
				cmd = CMD_INIT_WR;
				if (stat.init_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd     = CMD_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.err) begin
					state_d = S_FIN;
				end else begin
					unique case (stat.op)
						OP_PUSH: begin
							cmd     = CMD_RD_POS;
							state_d = S_PUSH_POS;
						end
						OP_POP: begin
							cmd     = CMD_POP_RD;
							state_d = S_POP_ROOT;
						end
						OP_QUERY: begin
							cmd     = CMD_RD_POS;
							state_d = S_Q_POS;
						end
						default: state_d = S_CLR_RD;
					endcase
				end
			end
			S_PUSH_POS: begin
				if (stat.pos_valid) begin
					cmd     = CMD_RD_SLOT_POS;
					state_d = S_PUSH_KEY;
				end else if (stat.held_full) begin
					state_d = S_FIN;
				end else begin
					cmd     = CMD_PUSH_NEW;
					state_d = S_UP;
				end
			end
			S_PUSH_KEY: state_d = stat.key_less ? S_UP : S_FIN;
			S_UP: begin
				if (stat.cur_zero) begin
					cmd     = CMD_PLACE;
					state_d = S_FIN;
				end else begin
					cmd     = CMD_UP_RD;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.parent_gt) begin
					cmd     = CMD_UP_SHIFT;
					state_d = S_UP;
				end else begin
					cmd     = CMD_PLACE;
					state_d = S_FIN;
				end
			end
			S_POP_ROOT: begin
				cmd     = CMD_POP_ROOT;
				state_d = S_POP_CHK;
			end
			S_POP_CHK: begin
				if (stat.held_zero) begin
					state_d = S_FIN;
				end else begin
					cmd     = CMD_POP_LAST;
					state_d = S_DN;
				end
			end
			S_DN: begin
				if (stat.dn_leaf) begin
					cmd     = CMD_PLACE;
					state_d = S_FIN;
				end else begin
					cmd     = CMD_DN_START;
					state_d = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				cmd = CMD_DN_CMP;
				if (!stat.dn_more) state_d = S_DN_MOVE;
			end
			S_DN_MOVE: begin
				if (stat.best_is_cur) begin
					cmd     = CMD_PLACE;
					state_d = S_FIN;
				end else begin
					cmd     = CMD_DN_SHIFT;
					state_d = S_DN;
				end
			end
			S_Q_POS: begin
				if (stat.pos_valid) begin
					cmd     = CMD_RD_SLOT_POS;
					state_d = S_Q_KEY;
				end else begin
					state_d = S_FIN;
				end
			end
			S_Q_KEY: begin
				cmd     = CMD_Q_FOUND;
				state_d = S_FIN;
			end
			S_CLR_RD: begin
				if (stat.clr_done) begin
					cmd     = CMD_CLR_END;
					state_d = S_FIN;
				end else begin
					cmd     = CMD_CLR_RD;
					state_d = S_CLR_WR;
				end
			end
			S_CLR_WR: begin
				cmd     = CMD_CLR_WR;
				state_d = S_CLR_RD;
			end
			S_FIN: begin
				cmd     = CMD_FIN;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

`default_nettype wire

>>> design/indexed_quad_min_heap.sv
// top level of the indexed quad min-heap: sequencer plus datapath
// depends on iqmh_pkg, iqmh_ctrl, iqmh_datapath (and through it iqmh_ram)
`timescale 1ns / 1ps
`default_nettype none

// one command at a time: a request transfers at a clock edge with start high and busy low,
// and exactly one result follows, shown for a single cycle with done high; the receiver
// cannot hold it off, so capture it on that cycle. after reset the block sweeps the
// position table with busy high. the single read port of each memory sets the pace of
// each operation: a push climbs one level at a time (after a position and key read to
// lower the key of a held node), a pop sinks one level at a time reading one child per
// cycle, and a clear reads and frees each held entry in turn.

module indexed_quad_min_heap import iqmh_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire req_t             request,
	output      logic             busy,
	input  wire logic             cfg_wr_en,
	input  wire logic [CNT_W-1:0] cfg_wr_data,
	output      logic             done,
	output      res_t             result
);

	// command and status between sequencer and datapath
	cmd_t     cmd;
	dp_stat_t stat;

	// sequencer: one state per memory access step of an operation
	iqmh_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.busy  (busy),
		.cmd   (cmd)
	);

	// datapath: heap slots, node-to-slot table, moving element and result registers
	iqmh_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.request    (request),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.stat       (stat),
		.done       (done),
		.result     (result)
	);

endmodule

`default_nettype wire

>>> design/iqmh_checker.sv
// port-level checks for the indexed quad min-heap, bound to the top level
// depends on iqmh_pkg and indexed_quad_min_heap
`timescale 1ns / 1ps
`default_nettype none

module iqmh_checker import iqmh_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire res_t result
);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("transfer did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.status <= STAT_RANGE) else $error("undefined status");

	a_err_node: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != STAT_OK |-> result.result_node == '0 && !result.found)
		else $error("error result carries data");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.entry_count <= CNT_W'(MAX_NODES)) else $error("count overflow");

endmodule

bind indexed_quad_min_heap iqmh_checker u_chk (.*);

`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for the indexed quad min-heap
// depends on iqmh_pkg and indexed_quad_min_heap; holds its own heap predictor
`timescale 1ns / 1ps

module testbench;
	import iqmh_pkg::*;

	typedef enum logic [1:0] {
		PEND_ITEM,
		PEND_CFG,
		PEND_SETTLE,
		PEND_IDLE
	} pend_kind_t;

	typedef struct {
		pend_kind_t       kind;
		req_t             item;
		logic [CNT_W-1:0] value;
	} pend_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	req_t             request = '0;
	logic             busy;
	logic             cfg_wr_en = 1'b0;
	logic [CNT_W-1:0] cfg_wr_data = '0;
	logic             done;
	res_t             result;

	// stimulus waiting for the driver, and outputs still to come back
	pend_t pending_cmds[$];
	res_t  expected_results[$];

	// predictor state: heap slots, node positions, held count and node limit
	logic [NODE_W-1:0]       heap_node [MAX_NODES];
	logic signed [KEY_W-1:0] heap_key  [MAX_NODES];
	logic [NODE_W-1:0]       node_slot [MAX_NODES];
	logic                    node_held [MAX_NODES];
	int unsigned             held_total = 0;
	int unsigned             node_limit = MAX_NODES;

	int unsigned error_count = 0;
	int unsigned checked_count = 0;
	int unsigned op_count [4] = '{0, 0, 0, 0};
	int unsigned sender_idle_pct = 0;
	int unsigned quiet_cycles = 0;
	int unsigned stim_limit = MAX_NODES;

	indexed_quad_min_heap i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.request    (request),
		.busy       (busy),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.done       (done),
		.result     (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		for (int n = 0; n < MAX_NODES; n++) begin
			node_held[n] = 1'b0;
			node_slot[n] = '0;
			heap_node[n] = '0;
			heap_key[n] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// swap two heap slots and keep the position table in step
	task automatic swap_heap(input int unsigned a, input int unsigned b);
		logic [NODE_W-1:0]       tn;
		logic signed [KEY_W-1:0] tk;
		tn = heap_node[a];
		tk = heap_key[a];
		heap_node[a] = heap_node[b];
		heap_key[a] = heap_key[b];
		heap_node[b] = tn;
		heap_key[b] = tk;
		node_slot[heap_node[a]] = a[NODE_W-1:0];
		node_slot[heap_node[b]] = b[NODE_W-1:0];
	endtask

	// climb while the parent holds a strictly larger key
	task automatic heap_climb(input int unsigned i);
		int unsigned p;
		while (i > 0) begin
			p = (i - 1) / 4;
			if (heap_key[p] <= heap_key[i])
				break;
			swap_heap(i, p);
			i = p;
		end
	endtask

	// sink towards the first strictly smallest child
	task automatic heap_sink(input int unsigned i);
		int unsigned first;
		int unsigned best;
		forever begin
			first = 4 * i + 1;
			best = i;
			if (first >= held_total)
				break;
			for (int unsigned c = first; c < first + 4 && c < held_total; c++)
				if (heap_key[c] < heap_key[best])
					best = c;
			if (best == i)
				break;
			swap_heap(i, best);
			i = best;
		end
	endtask

	// apply one command to the predictor and return the result it should give
	task automatic heap_apply(input req_t r, output res_t e);
		logic in_range;
		int unsigned pos;
		e = '0;
		in_range = (int'(r.node) < node_limit);
		case (r.operation)
			OP_PUSH: begin
				if (!in_range) begin
					e.status = STAT_RANGE;
				end else if (node_held[r.node]) begin
					pos = node_slot[r.node];
					if (r.priority_req < heap_key[pos]) begin
						heap_key[pos] = r.priority_req;
						heap_climb(pos);
					end
				end else if (held_total < MAX_NODES) begin
					heap_node[held_total] = r.node;
					heap_key[held_total] = r.priority_req;
					node_slot[r.node] = held_total[NODE_W-1:0];
					node_held[r.node] = 1'b1;
					held_total++;
					heap_climb(held_total - 1);
				end
			end
			OP_POP: begin
				if (held_total == 0) begin
					e.status = STAT_EMPTY;
				end else begin
					e.result_node = heap_node[0];
					e.result_priority = heap_key[0];
					node_held[heap_node[0]] = 1'b0;
					held_total--;
					if (held_total > 0) begin
						heap_node[0] = heap_node[held_total];
						heap_key[0] = heap_key[held_total];
						node_slot[heap_node[0]] = '0;
						heap_sink(0);
					end
				end
			end
			OP_QUERY: begin
				e.result_priority = KEY_ABSENT;
				if (!in_range) begin
					e.status = STAT_RANGE;
				end else if (node_held[r.node]) begin
					e.found = 1'b1;
					e.result_priority = heap_key[node_slot[r.node]];
				end
			end
			default: begin
				for (int unsigned i = 0; i < held_total; i++)
					node_held[heap_node[i]] = 1'b0;
				held_total = 0;
			end
		endcase
		e.entry_count = held_total[CNT_W-1:0];
	endtask

	// driver: one transfer per edge with start high and busy low
	always @(posedge clk) begin
		logic  next_start;
		logic  next_cfg;
		res_t  exp_res;
		pend_t head;
		next_start = start;
		next_cfg = 1'b0;
		if (arst_n) begin
			quiet_cycles = (expected_results.size() == 0 && !start) ? quiet_cycles + 1 : 0;
			if (start && !busy) begin
				// transfer taken at this edge
				heap_apply(request, exp_res);
				expected_results.push_back(exp_res);
				op_count[request.operation]++;
				next_start = 1'b0;
			end
			if (!(start && busy) && pending_cmds.size() > 0) begin
				head = pending_cmds[0];
				case (head.kind)
					PEND_ITEM: begin
						if ($urandom_range(99) >= sender_idle_pct) begin
							void'(pending_cmds.pop_front());
							request <= head.item;
							next_start = 1'b1;
						end
					end
					PEND_CFG: begin
						// only once the block has gone quiet
						if (!next_start && !start && !busy && quiet_cycles >= 4) begin
							void'(pending_cmds.pop_front());
							cfg_wr_data <= head.value;
							node_limit = head.value;
							next_cfg = 1'b1;
						end
					end
					PEND_SETTLE: begin
						if (!start && quiet_cycles >= 2)
							void'(pending_cmds.pop_front());
					end
					default: begin
						void'(pending_cmds.pop_front());
						sender_idle_pct = head.value;
					end
				endcase
			end
		end
		start <= next_start;
		cfg_wr_en <= next_cfg;
	end

	// monitor: every strobed result must match the oldest expectation
	always @(posedge clk) begin
		res_t exp_res;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result %p", $time, result);
			end else begin
				exp_res = expected_results.pop_front();
				checked_count++;
				if (result !== exp_res) begin
					error_count++;
					$display("%0t: mismatch expected %p actual %p", $time, exp_res, result);
				end
			end
		end
	end

	function automatic pend_t mk_item(input logic [1:0] op, input int unsigned node,
			input logic signed [KEY_W-1:0] key);
		pend_t p;
		p.kind = PEND_ITEM;
		p.item.operation = op;
		p.item.node = node[NODE_W-1:0];
		p.item.priority_req = key;
		p.value = '0;
		return p;
	endfunction

	function automatic pend_t mk_ctl(input pend_kind_t kind, input int unsigned value);
		pend_t p;
		p.kind = kind;
		p.item = '0;
		p.value = value[CNT_W-1:0];
		return p;
	endfunction

	function automatic logic signed [KEY_W-1:0] rand_key();
		case ($urandom_range(9))
			0:       return {1'b1, {(KEY_W-1){1'b0}}};
			1:       return KEY_ABSENT;
			2, 3, 4: return KEY_W'($signed($urandom_range(8)) - 4);
			default: return $urandom;
		endcase
	endfunction

	// random command mix, with nodes a little past the limit for range errors
	function automatic pend_t rand_item(input int unsigned lim);
		int unsigned top;
		int unsigned pick;
		logic [1:0]  op;
		top = lim + lim / 8 + 1;
		if (top > MAX_NODES - 1)
			top = MAX_NODES - 1;
		pick = $urandom_range(99);
		op = (pick < 48) ? OP_PUSH : (pick < 78) ? OP_POP : (pick < 97) ? OP_QUERY : OP_CLEAR;
		return mk_item(op, $urandom_range(top), rand_key());
	endfunction

	task automatic set_limit(input int unsigned lim);
		pending_cmds.push_back(mk_ctl(PEND_CFG, lim));
		stim_limit = lim;
	endtask

	initial begin
		int unsigned limits [6] = '{1024, 37, 1, 300, 4, 1024};
		// directed part: empty heap, key extremes, decrease and no-change pushes
		set_limit(MAX_NODES);
		pending_cmds.push_back(mk_item(OP_QUERY, 3, 0));
		pending_cmds.push_back(mk_item(OP_POP, 0, 0));
		pending_cmds.push_back(mk_item(OP_PUSH, 0, {1'b1, {(KEY_W-1){1'b0}}}));
		pending_cmds.push_back(mk_item(OP_PUSH, 1023, KEY_ABSENT));
		pending_cmds.push_back(mk_item(OP_PUSH, 5, 0));
		pending_cmds.push_back(mk_item(OP_PUSH, 6, 0));
		pending_cmds.push_back(mk_item(OP_PUSH, 5, -1));
		pending_cmds.push_back(mk_item(OP_PUSH, 5, 100));
		pending_cmds.push_back(mk_item(OP_PUSH, 6, 0));
		pending_cmds.push_back(mk_item(OP_QUERY, 5, 0));
		pending_cmds.push_back(mk_item(OP_QUERY, 1023, 0));
		pending_cmds.push_back(mk_item(OP_QUERY, 512, 0));
		pending_cmds.push_back(mk_item(OP_POP, 0, 0));
		pending_cmds.push_back(mk_item(OP_POP, 0, 0));
		pending_cmds.push_back(mk_item(OP_CLEAR, 0, 0));
		pending_cmds.push_back(mk_item(OP_POP, 0, 0));
		pending_cmds.push_back(mk_item(OP_PUSH, 2, 7));
		// shrink the limit with node 2 still held
		set_limit(1);
		pending_cmds.push_back(mk_item(OP_PUSH, 1, 3));
		pending_cmds.push_back(mk_item(OP_QUERY, 2, 0));
		pending_cmds.push_back(mk_item(OP_PUSH, 0, 9));
		pending_cmds.push_back(mk_item(OP_POP, 0, 0));
		pending_cmds.push_back(mk_item(OP_POP, 0, 0));
		pending_cmds.push_back(mk_item(OP_PUSH, 0, 1));
		pending_cmds.push_back(mk_item(OP_CLEAR, 0, 0));

		// random part: three idle schemes, each over two limit settings
		for (int ph = 0; ph < 3; ph++) begin
			pending_cmds.push_back(mk_ctl(PEND_IDLE, (ph == 0) ? 6 : (ph == 1) ? 63 : 0));
			for (int s = 0; s < 2; s++) begin
				set_limit(limits[2 * ph + s]);
				for (int k = 0; k < 105; k++)
					pending_cmds.push_back(rand_item(stim_limit));
				// hold off until every output is back
				pending_cmds.push_back(mk_ctl(PEND_SETTLE, 0));
			end
		end

		// fill the heap completely, push once more while full, then drain a little
		set_limit(MAX_NODES);
		pending_cmds.push_back(mk_item(OP_CLEAR, 0, 0));
		for (int n = 0; n < MAX_NODES; n++)
			pending_cmds.push_back(mk_item(OP_PUSH, n, rand_key()));
		pending_cmds.push_back(mk_item(OP_PUSH, 700, {1'b1, {(KEY_W-1){1'b0}}}));
		for (int k = 0; k < 60; k++)
			pending_cmds.push_back(rand_item(stim_limit));
		pending_cmds.push_back(mk_item(OP_CLEAR, 0, 0));

		wait (arst_n);
		while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d pushes, %0d pops, %0d queries, %0d clears; %0d results checked",
			op_count[OP_PUSH], op_count[OP_POP], op_count[OP_QUERY], op_count[OP_CLEAR],
			checked_count);
		$display("node limits from 1 to 1024, sender idling at 6, 63 and 0 percent, full heap");
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// run limit, far above the slowest legal run
	initial begin
		#60_000_000;
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
